### rtl/core/sliding_window_min_index_macros.svh
// Assertion macros shared by the checker of the sliding window minimum block.
`ifndef SLIDING_WINDOW_MIN_INDEX_MACROS_SVH
`define SLIDING_WINDOW_MIN_INDEX_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SWMI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sliding window minimum: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define SWMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sliding window minimum: next-cycle check failed");

// Next-cycle implication that is also checked while reset is held.
`define SWMI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sliding window minimum: reset check failed");

`endif

### rtl/core/swmi_pkg.sv
// Shared types, constants and helpers of the sliding window minimum block.
`timescale 1ns / 1ps
package swmi_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int WIN_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = 7;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W       = 32;

  localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

  localparam logic [7:0] CFG_WINDOW_LENGTH = 8'd0;
  localparam logic [7:0] CFG_START_INDEX   = 8'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]              index_t;
  typedef logic [LEN_W-1:0]              len_t;

  typedef struct packed {
    len_t   window_length;
    index_t start_index;
  } cfg_t;

  typedef struct packed {
    index_t min_index;
    index_t sample_index;
    logic   last_result;
  } res_t;

  // A length of zero counts as one; anything above the store depth is clipped.
  function automatic len_t eff_len(input len_t len);
    len_t r;
    r = len;
    if (len == '0) begin
      r = len_t'(1);
    end else if (len > len_t'(MAX_WINDOW)) begin
      r = len_t'(MAX_WINDOW);
    end
    return r;
  endfunction

endpackage

### rtl/core/swmi_cell.sv
// One cell of the sample chain: a sample register that loads from its neighbour.
`timescale 1ns / 1ps
module swmi_cell (
  input  logic              clk,
  input  logic              en,
  input  swmi_pkg::sample_t d_in,
  output swmi_pkg::sample_t d_out
);
  import swmi_pkg::*;

  sample_t value_r;

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= d_in;
    end
  end

  assign d_out = value_r;

endmodule

### rtl/core/swmi_core.sv
// Sample chain, minimum tracking and rescan sequencer of the window minimum block.
`timescale 1ns / 1ps
module swmi_core (
  input  logic              clk,
  input  logic              rst_n,
  input  swmi_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  swmi_pkg::sample_t in_sample,
  input  logic              in_first,
  input  logic              in_last,
  output logic              res_valid,
  output swmi_pkg::res_t    res,
  input  logic              res_pop
);
  import swmi_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic [WIN_W-1:0] step_r, step_nxt;

  index_t  idx_r, idx_nxt;
  logic    sat_r, sat_nxt;
  logic    have_r, have_nxt;
  sample_t minval_r, minval_nxt;
  index_t  minpos_r, minpos_nxt;

  len_t    lenm1_r, lenm1_nxt;
  index_t  now_r, now_nxt;
  logic    last_r, last_nxt;
  sample_t best_r, best_nxt;
  logic [WIN_W-1:0] bestj_r, bestj_nxt;

  logic res_valid_r, res_valid_nxt;
  res_t res_r, res_nxt;

  sample_t chain_q [MAX_WINDOW];
  sample_t head_in;
  logic    shift_all, head_only;

  logic    accept;
  index_t  now;
  logic    have_eff, sat_eff;
  sample_t minval_eff;
  index_t  minpos_eff;
  len_t    lenm1;
  logic    emit, expired;
  logic [IDX_W:0] reach;

  logic [WIN_W-1:0] j;
  logic    active, init;
  sample_t tap, cand_val;
  logic [WIN_W-1:0] cand_j;

  // The chain shifts one place per new sample, so cell k holds the sample k places back.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic en_k;
    sample_t din_k;
    if (k == 0) begin : g_head
      assign en_k  = shift_all | head_only;
      assign din_k = head_in;
    end else begin : g_body
      assign en_k  = shift_all;
      assign din_k = chain_q[k-1];
    end
    swmi_cell u_cell (
      .clk   (clk),
      .en    (en_k),
      .d_in  (din_k),
      .d_out (chain_q[k])
    );
  end

  assign in_ready  = (state_r == ST_IDLE) && !res_valid_r;
  assign accept    = in_valid && in_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign now        = in_first ? '0 : idx_r;
  assign have_eff   = in_first ? 1'b0 : have_r;
  assign sat_eff    = in_first ? 1'b0 : sat_r;
  assign minval_eff = in_first ? '0 : minval_r;
  assign minpos_eff = in_first ? '0 : minpos_r;

  assign lenm1   = eff_len(cfg.window_length) - len_t'(1);
  assign emit    = (index_t'(lenm1) <= now) && (cfg.start_index <= now);
  assign reach   = {1'b0, minpos_eff} + (IDX_W+1)'(lenm1);
  assign expired = reach < {1'b0, now};

  // During a rescan the chain rotates once round; the last cell is the tap,
  // and cell offset j passes it at step ~j, oldest first.
  assign tap    = chain_q[MAX_WINDOW-1];
  assign j      = ~step_r;
  assign active = len_t'(j) <= lenm1_r;
  assign init   = len_t'(j) == lenm1_r;

  always_comb begin
    cand_val = best_r;
    cand_j   = bestj_r;
    if (active && (init || (tap < best_r))) begin
      cand_val = tap;
      cand_j   = j;
    end
  end

  // Once the index has saturated, a new sample replaces the newest entry in place.
  assign shift_all = (accept && !sat_eff) || (state_r == ST_SCAN);
  assign head_only = accept && sat_eff;
  assign head_in   = (state_r == ST_SCAN) ? tap : in_sample;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    sat_nxt       = sat_r;
    have_nxt      = have_r;
    minval_nxt    = minval_r;
    minpos_nxt    = minpos_r;
    lenm1_nxt     = lenm1_r;
    now_nxt       = now_r;
    last_nxt      = last_r;
    best_nxt      = best_r;
    bestj_nxt     = bestj_r;
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;

    if (res_pop) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt    = (now == INDEX_MAX) ? now : now + index_t'(1);
          sat_nxt    = (now == INDEX_MAX);
          have_nxt   = have_eff;
          minval_nxt = minval_eff;
          minpos_nxt = minpos_eff;
          if (!emit) begin
            have_nxt = 1'b0;
          end else if (!have_eff || expired) begin
            state_nxt = ST_SCAN;
            step_nxt  = '0;
            lenm1_nxt = lenm1;
            now_nxt   = now;
            last_nxt  = in_last;
          end else begin
            if (in_sample <= minval_eff) begin
              minval_nxt = in_sample;
              minpos_nxt = now;
            end
            res_valid_nxt         = 1'b1;
            res_nxt.min_index     = (in_sample <= minval_eff) ? now : minpos_eff;
            res_nxt.sample_index  = now;
            res_nxt.last_result   = in_last;
          end
        end
      end
      ST_SCAN: begin
        best_nxt  = cand_val;
        bestj_nxt = cand_j;
        step_nxt  = step_r + WIN_W'(1);
        if (step_r == {WIN_W{1'b1}}) begin
          state_nxt            = ST_IDLE;
          have_nxt             = 1'b1;
          minval_nxt           = cand_val;
          minpos_nxt           = now_r - index_t'(cand_j);
          res_valid_nxt        = 1'b1;
          res_nxt.min_index    = now_r - index_t'(cand_j);
          res_nxt.sample_index = now_r;
          res_nxt.last_result  = last_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      idx_r       <= '0;
      sat_r       <= 1'b0;
      have_r      <= 1'b0;
      minval_r    <= '0;
      minpos_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      sat_r       <= sat_nxt;
      have_r      <= have_nxt;
      minval_r    <= minval_nxt;
      minpos_r    <= minpos_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lenm1_r <= lenm1_nxt;
    now_r   <= now_nxt;
    last_r  <= last_nxt;
    best_r  <= best_nxt;
    bestj_r <= bestj_nxt;
    res_r   <= res_nxt;
  end

endmodule

### rtl/core/sliding_window_min_index.sv
// Top level of the sliding window minimum index block.
//
//   channel  direction  handshake                 payload
//   in_      slave      in_tvalid / in_tready     tdata sample, tuser first, tlast last
//   out_     master     out_tvalid / out_tready   tdata min_index, sample_index; tlast
//   cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A sample whose stored minimum is still inside the window passes through the core's
// result register and then the output register. On an expired minimum or the
// first emitting sample the MAX_WINDOW cells first rotate past one comparator.
// Reset clears only the control state; the sample chain needs no clearing pass.
// A finished result waits in the output register while one more sample can be
// taken and its result held inside the core; cfg_ready is always high.
`timescale 1ns / 1ps
module sliding_window_min_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic        in_tuser,   // [0] first_sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] min_index, [63:32] sample_index
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import swmi_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic res_valid, res_pop;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: cfg_nxt.window_length = cfg_data[LEN_W-1:0];
        CFG_START_INDEX:   cfg_nxt.start_index   = cfg_data[IDX_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  swmi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (sample_t'(in_tdata)),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (res_pop)
  );

  assign res_pop = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_pop) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length <= len_t'(30);
      cfg_r.start_index   <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.sample_index, out_r.min_index};
  assign out_tlast  = out_r.last_result;

endmodule

### rtl/core/sliding_window_min_index_checker.sv
// Port-level checks of the sliding window minimum index block and their binding.
`timescale 1ns / 1ps
`include "sliding_window_min_index_macros.svh"
module sliding_window_min_index_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // A stalled result transaction is not withdrawn.
  `SWMI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // The window minimum can never lie after the sample that produced it.
  `SWMI_ASSERT_SAME(a_min_not_ahead, clk, rst_n, out_tvalid, out_tdata[31:0] <= out_tdata[63:32])

  // No result is offered straight after a reset cycle.
  `SWMI_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_tvalid)

endmodule

bind sliding_window_min_index sliding_window_min_index_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### sim/tb_top.sv
// Self-checking testbench for the sliding window minimum index block.
`timescale 1ns / 1ps
module tb_top;
  import swmi_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1930;
  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] CFG_SPARE = 8'd2;

  typedef enum int {STYLE_WIDE, STYLE_TIES, STYLE_EXTREMES, STYLE_RISING, STYLE_FALLING}
    sample_style_e;

  // Tracks the window, its minimum and the index counter, and holds the
  // results still owed by the block.
  class min_index_scoreboard;
    sample_t win_store[MAX_WINDOW];
    sample_t low_value;
    index_t  low_index;
    bit      low_valid;
    index_t  next_index;
    len_t    win_len;
    index_t  emit_from;
    res_t    pending[$];
    int      failures;

    function new();
      low_value  = '0;
      low_index  = '0;
      low_valid  = 1'b0;
      next_index = '0;
      win_len    = len_t'(30);
      emit_from  = '0;
      failures   = 0;
    endfunction

    function void note_sample(input sample_t value, input logic is_first, input logic is_last);
      int unsigned span;
      index_t      here;
      index_t      oldest;
      index_t      pos;
      index_t      threshold;
      res_t        want;
      span = (win_len == '0) ? 1 : ((win_len > len_t'(MAX_WINDOW)) ? MAX_WINDOW : win_len);
      if (is_first) begin
        next_index = '0;
        low_valid  = 1'b0;
        low_value  = '0;
        low_index  = '0;
      end
      here = next_index;
      win_store[here[WIN_W-1:0]] = value;
      if (next_index != INDEX_MAX) begin
        next_index = next_index + 1;
      end
      threshold = index_t'(span - 1);
      if (emit_from > threshold) begin
        threshold = emit_from;
      end
      if (here < threshold) begin
        low_valid = 1'b0;
        return;
      end
      oldest = here - index_t'(span - 1);
      if (!low_valid || low_index < oldest) begin
        // The minimum has left the window: scan oldest first, earliest tie wins.
        low_index = oldest;
        low_value = win_store[oldest[WIN_W-1:0]];
        for (int unsigned k = 1; k < span; k++) begin
          pos = oldest + index_t'(k);
          if (win_store[pos[WIN_W-1:0]] < low_value) begin
            low_value = win_store[pos[WIN_W-1:0]];
            low_index = pos;
          end
        end
        low_valid = 1'b1;
      end else if (value <= low_value) begin
        low_value = value;
        low_index = here;
      end
      want.min_index    = low_index;
      want.sample_index = here;
      want.last_result  = is_last;
      pending.push_back(want);
    endfunction

    function void check_result(input logic [63:0] data, input logic tlast);
      res_t want;
      res_t got;
      got.min_index    = data[31:0];
      got.sample_index = data[63:32];
      got.last_result  = tlast;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("unexpected result: min_index %0d sample_index %0d last %0b",
                   got.min_index, got.sample_index, got.last_result);
        end
        return;
      end
      want = pending.pop_front();
      if (got.min_index !== want.min_index || got.sample_index !== want.sample_index ||
          got.last_result !== want.last_result) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result differs: expected min_index %0d sample_index %0d last %0b, got %0d %0d %0b",
                   want.min_index, want.sample_index, want.last_result,
                   got.min_index, got.sample_index, got.last_result);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] sample
  logic        in_tuser = 1'b0; // [0] first_sample
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] min_index, [63:32] sample_index
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  min_index_scoreboard sb = new();
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit long_hold_req = 1'b0;

  always #1 clk = ~clk;

  sliding_window_min_index dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int draw_gap(input bit enabled);
    return enabled ? int'($urandom_range(8)) : 0;
  endfunction

  function automatic sample_t draw_sample(input sample_style_e style, input sample_t prev);
    case (style)
      STYLE_TIES: return sample_t'($urandom_range(6)) - sample_t'(3);
      STYLE_EXTREMES: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      // A rising series keeps the minimum at the oldest sample, so it expires often.
      STYLE_RISING:  return prev + sample_t'($urandom_range(3));
      STYLE_FALLING: return prev - sample_t'($urandom_range(3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_WINDOW_LENGTH: sb.win_len = value[LEN_W-1:0];
      CFG_START_INDEX:   sb.emit_from = value;
      default: ;
    endcase
  endtask

  task automatic configure(input len_t len, input index_t start, input bit poke_spare);
    if (poke_spare) begin
      write_reg(CFG_SPARE, $urandom);
    end
    write_reg(CFG_WINDOW_LENGTH, {{(32-LEN_W){1'b0}}, len});
    write_reg(CFG_START_INDEX, start);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input sample_t value, input logic is_first, input logic is_last);
    int gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= is_first;
    in_tlast  <= is_last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_sample(value, is_first, is_last);
  endtask

  // Stop offering samples until every owed result has arrived, then let the
  // bench idle for a further tail before the next section.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = draw_gap(recv_idle);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_result(out_tdata, out_tlast);
    end
  end

  initial begin : stimulus
    int            sent;
    int            count;
    len_t          len;
    index_t        start;
    sample_style_e style;
    sample_style_e style_now;
    sample_t       prev;
    logic          is_first;
    logic          is_last;
    sent = 0;
    prev = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, tie breaking both ways, expiry and the last-sample flag.
    configure(len_t'(4), '0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    send_sample(-32'sd1, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b1);
    send_sample(32'sd7, 1'b0, 1'b0);
    send_sample(32'sd3, 1'b1, 1'b1);
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    settle();

    // A zero length acts as a window of one sample.
    configure('0, '0, 1'b1);
    send_sample(32'sd5, 1'b1, 1'b0);
    send_sample(32'sd5, 1'b0, 1'b0);
    send_sample(-32'sd7, 1'b0, 1'b1);
    settle();

    // The highest start index keeps the block silent.
    configure(len_t'(4), '1, 1'b0);
    send_sample(32'sh5555_5555, 1'b0, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0, 1'b1);
    send_sample(32'sd1, 1'b0, 1'b0);
    settle();

    // Hold the result side off long enough for the input to back up.
    configure(len_t'(2), '0, 1'b0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    long_hold_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      prev = draw_sample(STYLE_WIDE, prev);
      send_sample(prev, (n == 0), ($urandom_range(15) == 0));
    end
    sent = 60;
    settle();

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(7))
        0: len = '0;
        1: len = len_t'(1);
        2: len = len_t'(2);
        3: len = len_t'(MAX_WINDOW);
        4: len = '1;
        5: len = len_t'(MAX_WINDOW + 1);
        default: len = len_t'($urandom_range(1, 127));
      endcase
      count = $urandom_range(40, 160);
      case ($urandom_range(9))
        5, 6, 7: start = index_t'($urandom_range(1, 100));
        8: begin
          start = index_t'($urandom);
          count = 20;
        end
        9: begin
          start = '1;
          count = 10;
        end
        default: start = '0;
      endcase
      style = sample_style_e'($urandom_range(4));
      send_idle = ($urandom_range(2) != 0);
      recv_idle = ($urandom_range(2) != 0);
      configure(len, start, 1'b0);
      for (int n = 0; n < count; n++) begin
        is_first  = (n == 0) ? ($urandom_range(2) == 0) : ($urandom_range(63) == 0);
        is_last   = ($urandom_range(15) == 0);
        style_now = ($urandom_range(4) == 0) ? STYLE_WIDE : style;
        prev = draw_sample(style_now, prev);
        send_sample(prev, is_first, is_last);
      end
      sent += count;
      settle();
    end

    sb.failures += sb.pending.size();
    if (sb.failures == 0) begin
      $display("sliding_window_min_index: match");
    end else begin
      $display("sliding_window_min_index: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("sliding_window_min_index: mismatch");
    $finish;
  end

endmodule
